// ===== hdl/lldq_pkg.sv =====
package lldq_pkg;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_INSERT     = 3'd2;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [2:0] CMD_POP_BACK   = 3'd4;
  localparam logic [2:0] CMD_REMOVE     = 3'd5;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int COUNT_W = 7;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [VAL_W-1:0] val_t;

endpackage

// ===== hdl/linked_list_deque_engine_core.sv =====
// Channel | Signals                                        | Direction
// input   | in_valid, in_ready, cmd, entry_key, entry_value | into block
// output  | out_valid, out_ready, ok, count, front_key,     | out of block
//         | front_value, back_key, back_value               |
//
// One transaction at a time; in_ready is high only in idle. A rejected or
// unknown command goes straight to reading the head (S_RDF) and the tail
// (S_RDB), then S_FIN and S_OUT. Push back or a push into an empty list first
// writes in S_LINK2; push front reads the old head in S_LINK before that; a pop
// reads the victim's links (S_UNRD) and patches its neighbors (S_UNLNK). Walks
// visit each slot in S_WALK (read issue), then S_CHECK (compare on the
// registered data); insert and remove walk from the head. A free-slot search
// uses a priority encoder over the free map.
// rst (synchronous) empties the list and frees all slots; slot memory itself
// keeps its contents. A stalled result holds in the output register and the
// block takes no new transaction until it is taken.
module linked_list_deque_engine_core
  import lldq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          cmd,
  input  logic signed [31:0]  entry_key,
  input  logic signed [31:0]  entry_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                ok,
  output logic [COUNT_W-1:0]  count,
  output logic signed [31:0]  front_key,
  output logic signed [31:0]  front_value,
  output logic signed [31:0]  back_key,
  output logic signed [31:0]  back_value
);

  localparam int AW = $clog2(CAPACITY + 1);  // slot index incl. null marker
  localparam int IW = $clog2(CAPACITY);      // memory address
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] NIL = AW'(CAPACITY);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_WALK   = 4'd1;  // issue read of cur
  localparam logic [3:0] S_CHECK  = 4'd2;  // read data of cur valid
  localparam logic [3:0] S_LINK   = 4'd3;  // read backward of "at"
  localparam logic [3:0] S_LINK2  = 4'd4;  // write new slot and neighbors
  localparam logic [3:0] S_UNRD   = 4'd5;  // read links of victim
  localparam logic [3:0] S_UNLNK  = 4'd6;  // patch neighbors
  localparam logic [3:0] S_RDF    = 4'd7;  // read head
  localparam logic [3:0] S_RDB    = 4'd8;  // read tail
  localparam logic [3:0] S_FIN    = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  // slot memory: one read port, registered data
  key_t          mem_key [CAPACITY];
  val_t          mem_val [CAPACITY];
  logic [AW-1:0] mem_fwd [CAPACITY];
  logic [AW-1:0] mem_bwd [CAPACITY];

  logic [3:0]          state;
  logic [CAPACITY-1:0] free_map;
  logic [AW-1:0]       head_slot, tail_slot;
  logic [CW-1:0]       entry_count;
  logic [2:0]          op;
  key_t                op_key;
  val_t                op_val;
  logic [AW-1:0]       cur, at, new_slot, victim;
  logic [CW-1:0]       steps;
  logic                done_ok;

  logic [IW-1:0] rd_addr;
  key_t          rd_key;
  val_t          rd_val;
  logic [AW-1:0] rd_fwd, rd_bwd;

  logic [IW-1:0] free_idx;
  logic          has_free;

  always_comb begin
    free_idx = '0;
    has_free = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        free_idx = IW'(i);
        has_free = 1'b1;
      end
    end
  end

  // read address chosen by state
  always_comb begin
    case (state)
      S_WALK:  rd_addr = cur[IW-1:0];
      S_LINK:  rd_addr = at[IW-1:0];
      S_UNRD:  rd_addr = victim[IW-1:0];
      S_RDF:   rd_addr = head_slot[IW-1:0];
      S_RDB:   rd_addr = tail_slot[IW-1:0];
      default: rd_addr = cur[IW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    rd_key <= mem_key[rd_addr];
    rd_val <= mem_val[rd_addr];
    rd_fwd <= mem_fwd[rd_addr];
    rd_bwd <= mem_bwd[rd_addr];
  end

  // link writes (memory has no reset)
  always_ff @(posedge clk) begin
    if (state == S_LINK2) begin
      mem_key[new_slot[IW-1:0]] <= op_key;
      mem_val[new_slot[IW-1:0]] <= op_val;
      if (at == NIL) begin
        mem_bwd[new_slot[IW-1:0]] <= tail_slot;
        mem_fwd[new_slot[IW-1:0]] <= NIL;
        if (tail_slot != NIL) mem_fwd[tail_slot[IW-1:0]] <= new_slot;
      end else begin
        mem_fwd[new_slot[IW-1:0]] <= at;
        mem_bwd[new_slot[IW-1:0]] <= rd_bwd;
        mem_bwd[at[IW-1:0]] <= new_slot;
        if (rd_bwd != NIL) mem_fwd[rd_bwd[IW-1:0]] <= new_slot;
      end
    end else if (state == S_UNLNK) begin
      if (rd_bwd != NIL) mem_fwd[rd_bwd[IW-1:0]] <= rd_fwd;
      if (rd_fwd != NIL) mem_bwd[rd_fwd[IW-1:0]] <= rd_bwd;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      free_map    <= '1;
      head_slot   <= NIL;
      tail_slot   <= NIL;
      entry_count <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          op      <= cmd;
          op_key  <= entry_key;
          op_val  <= entry_value;
          cur     <= head_slot;
          steps   <= '0;
          new_slot <= {1'b0, free_idx};
          if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK || cmd == CMD_INSERT) begin
            if (entry_count < CW'(CAPACITY) && has_free) begin
              free_map[free_idx] <= 1'b0;
              done_ok <= 1'b1;
              if (cmd == CMD_PUSH_FRONT) begin
                at <= head_slot;
                state <= (head_slot == NIL) ? S_LINK2 : S_LINK;
              end else if (cmd == CMD_PUSH_BACK) begin
                at <= NIL;
                state <= S_LINK2;
              end else begin
                state <= S_WALK;
              end
            end else begin
              done_ok <= 1'b0;
              state <= S_RDF;
            end
          end else if (cmd == CMD_POP_FRONT || cmd == CMD_POP_BACK) begin
            done_ok <= 1'b0;
            if (entry_count != '0 && head_slot != NIL && tail_slot != NIL) begin
              victim <= (cmd == CMD_POP_FRONT) ? head_slot : tail_slot;
              state <= S_UNRD;
            end else begin
              state <= S_RDF;
            end
          end else if (cmd == CMD_REMOVE) begin
            done_ok <= 1'b0;
            state <= S_WALK;
          end else begin
            done_ok <= 1'b0;
            state <= S_RDF;
          end
        end
        S_WALK: begin
          if (cur == NIL || steps >= CW'(CAPACITY)) begin
            if (op == CMD_INSERT) begin
              at <= NIL;
              state <= S_LINK2;
            end else begin
              state <= S_RDF;
            end
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (op == CMD_INSERT) begin
            if ($signed(rd_val) >= $signed(op_val)) begin
              at <= cur;
              state <= S_LINK;
            end else begin
              cur <= rd_fwd;
              steps <= steps + 1'b1;
              state <= S_WALK;
            end
          end else begin
            if (rd_key == op_key) begin
              victim <= cur;
              done_ok <= 1'b1;
              state <= S_UNRD;
            end else begin
              cur <= rd_fwd;
              steps <= steps + 1'b1;
              state <= S_WALK;
            end
          end
        end
        S_LINK: state <= S_LINK2;
        S_LINK2: begin
          if (at == NIL) begin
            if (tail_slot == NIL) head_slot <= new_slot;
            tail_slot <= new_slot;
          end else if (rd_bwd == NIL) begin
            head_slot <= new_slot;
          end
          entry_count <= entry_count + 1'b1;
          state <= S_RDF;
        end
        S_UNRD: state <= S_UNLNK;
        S_UNLNK: begin
          if (rd_bwd == NIL) head_slot <= rd_fwd;
          if (rd_fwd == NIL) tail_slot <= rd_bwd;
          free_map[victim[IW-1:0]] <= 1'b1;
          if (entry_count != '0) entry_count <= entry_count - 1'b1;
          done_ok <= 1'b1;
          state <= S_RDF;
        end
        S_RDF: state <= S_RDB;
        S_RDB: begin
          front_key   <= rd_key;
          front_value <= rd_val;
          state <= S_FIN;
        end
        S_FIN: begin
          ok    <= done_ok;
          count <= COUNT_W'(entry_count);
          if (entry_count != '0 && head_slot != NIL && tail_slot != NIL) begin
            back_key   <= rd_key;
            back_value <= rd_val;
          end else begin
            front_key   <= '0;
            front_value <= '0;
            back_key    <= '0;
            back_value  <= '0;
          end
          state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(CAPACITY))
    else $error("entry count above capacity");
  a_empty_nil: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && entry_count == '0) |-> (head_slot == NIL && tail_slot == NIL))
    else $error("empty list with linked ends");
  a_free_track: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> ($countones(free_map) + entry_count == CAPACITY))
    else $error("free map out of step with count");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(ok) && $stable(count)))
    else $error("result dropped while stalled");
`endif

endmodule

// ===== test/linked_list_deque_engine_core_tb.sv =====
module linked_list_deque_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lldq_pkg::*;

  localparam int CAP = 64;

  // Golden list: an ordered queue of entries stands in for the linked slots.
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] value;
  } entry_t;

  typedef struct packed {
    logic        ok;
    logic [6:0]  count;
    logic [31:0] front_key;
    logic [31:0] front_value;
    logic [31:0] back_key;
    logic [31:0] back_value;
  } status_t;

  class deque_scoreboard;
    entry_t  list_q[$];
    status_t pending_q[$];
    int      errors;
    int      checked;
    int      op_hits[8];
    int      fail_hits;

    function void note_command(logic [2:0] op, logic [31:0] key, logic [31:0] value);
      status_t st;
      entry_t  e;
      int      pos;
      logic    done;
      done = 1'b0;
      e.key = key;
      e.value = value;
      op_hits[op]++;
      case (op)
        CMD_PUSH_FRONT: begin
          if (list_q.size() < CAP) begin
            list_q.push_front(e);
            done = 1'b1;
          end
        end
        CMD_PUSH_BACK: begin
          if (list_q.size() < CAP) begin
            list_q.push_back(e);
            done = 1'b1;
          end
        end
        CMD_INSERT: begin
          if (list_q.size() < CAP) begin
            pos = list_q.size();
            // first entry whose data is >= new data, signed compare
            for (int i = list_q.size() - 1; i >= 0; i--) begin
              if ($signed(list_q[i].value) >= $signed(value)) pos = i;
            end
            list_q.insert(pos, e);
            done = 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          if (list_q.size() > 0) begin
            void'(list_q.pop_front());
            done = 1'b1;
          end
        end
        CMD_POP_BACK: begin
          if (list_q.size() > 0) begin
            void'(list_q.pop_back());
            done = 1'b1;
          end
        end
        CMD_REMOVE: begin
          for (int i = 0; i < list_q.size(); i++) begin
            if (!done && list_q[i].key == key) begin
              list_q.delete(i);
              done = 1'b1;
            end
          end
        end
        default: ;
      endcase
      if (!done) fail_hits++;
      st.ok = done;
      st.count = 7'(list_q.size());
      if (list_q.size() > 0) begin
        st.front_key = list_q[0].key;
        st.front_value = list_q[0].value;
        st.back_key = list_q[$].key;
        st.back_value = list_q[$].value;
      end else begin
        st.front_key = '0;
        st.front_value = '0;
        st.back_key = '0;
        st.back_value = '0;
      end
      pending_q.push_back(st);
    endfunction

    function void check_status(status_t got);
      status_t want;
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result: got %h", $time, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (got.ok !== want.ok) begin
        $display("%0t ok mismatch: exp %0d got %0d", $time, want.ok, got.ok);
        errors++;
      end
      if (got.count !== want.count) begin
        $display("%0t count mismatch: exp %0d got %0d", $time, want.count, got.count);
        errors++;
      end
      if (got.front_key !== want.front_key) begin
        $display("%0t front_key mismatch: exp %h got %h", $time, want.front_key,
                 got.front_key);
        errors++;
      end
      if (got.front_value !== want.front_value) begin
        $display("%0t front_value mismatch: exp %h got %h", $time, want.front_value,
                 got.front_value);
        errors++;
      end
      if (got.back_key !== want.back_key) begin
        $display("%0t back_key mismatch: exp %h got %h", $time, want.back_key,
                 got.back_key);
        errors++;
      end
      if (got.back_value !== want.back_value) begin
        $display("%0t back_value mismatch: exp %h got %h", $time, want.back_value,
                 got.back_value);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  cmd = '0;
  logic signed [31:0] entry_key = '0;
  logic signed [31:0] entry_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        ok;
  logic [COUNT_W-1:0] count;
  logic signed [31:0] front_key, front_value, back_key, back_value;

  deque_scoreboard board = new();
  int  stall_hold = 0;      // receiver hold-off, in cycles
  bit  hold_req = 1'b0;     // toggled by the sender to start a hold-off
  bit  hold_ack = 1'b0;
  bit  calm = 1'b0;         // stretch with no idling on either side
  int  max_depth = 0;

  always #5 clk = ~clk;

  linked_list_deque_engine_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .entry_key(entry_key), .entry_value(entry_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .ok(ok), .count(count),
    .front_key(front_key), .front_value(front_value),
    .back_key(back_key), .back_value(back_value)
  );

  // Receiver: random stalls plus an occasional long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      stall_hold <= 300;
      out_ready <= 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 11);
    end
  end

  // Results are sampled at the edge where the transaction completes.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.check_status({ok, count, front_key, front_value, back_key, back_value});
    end
  end

  // Offer one transaction and hold it until taken; the random idle gap comes first,
  // so valid stays high after a handshake unless a gap follows.
  task automatic send_cmd(logic [2:0] op, logic [31:0] key, logic [31:0] value);
    if (!calm) begin
      while ($urandom_range(99) < 11) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    cmd <= op;
    entry_key <= key;
    entry_value <= value;
    do @(posedge clk); while (!in_ready);
    board.note_command(op, key, value);
    if (board.list_q.size() > max_depth) max_depth = board.list_q.size();
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    release_input();
    while (board.pending_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // Keys from a small pool so that removes usually hit something.
  function automatic logic [31:0] pool_key();
    if ($urandom_range(9) == 0) return pick_word();
    return $urandom_range(15);
  endfunction

  function automatic logic [31:0] pool_value();
    if ($urandom_range(3) == 0) return pick_word();
    return $signed($urandom_range(40)) - 20;
  endfunction

  initial begin
    logic [2:0] op;
    int fill;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: failures on empty, extremes, every command, unknown codes.
    send_cmd(CMD_POP_FRONT, 0, 0);
    send_cmd(CMD_POP_BACK, 0, 0);
    send_cmd(CMD_REMOVE, 32'h7fff_ffff, 0);
    send_cmd(CMD_PUSH_FRONT, 32'h8000_0000, 32'h7fff_ffff);
    send_cmd(CMD_PUSH_BACK, 32'h7fff_ffff, 32'h8000_0000);
    send_cmd(CMD_INSERT, 32'hffff_ffff, 32'h0);
    send_cmd(CMD_INSERT, 32'h1, 32'h8000_0000);
    send_cmd(CMD_INSERT, 32'h2, 32'h7fff_ffff);
    send_cmd(CMD_INSERT, 32'h3, 32'hffff_ffff);
    send_cmd(3'd6, 32'h5, 32'h5);
    send_cmd(3'd7, 32'hffff_ffff, 32'hffff_ffff);
    send_cmd(CMD_REMOVE, 32'h1234_5678, 0);
    send_cmd(CMD_REMOVE, 32'hffff_ffff, 0);
    send_cmd(CMD_REMOVE, 32'h7fff_ffff, 0);
    send_cmd(CMD_POP_BACK, 0, 0);
    send_cmd(CMD_POP_FRONT, 0, 0);

    // Fill to capacity with ordered inserts, then overflow each push kind.
    while (board.list_q.size() < CAP) send_cmd(CMD_INSERT, pool_key(), pool_value());
    send_cmd(CMD_PUSH_FRONT, 1, 1);
    send_cmd(CMD_PUSH_BACK, 2, 2);
    send_cmd(CMD_INSERT, 3, 3);
    send_cmd(CMD_REMOVE, board.list_q[$].key, 0);   // walk up to the whole list

    // Receiver holds off while the sender keeps offering.
    drain_results();
    hold_req <= ~hold_req;
    for (int i = 0; i < 20; i++) send_cmd(CMD_POP_BACK, 0, 0);
    drain_results();

    // Random phases: each one drifts toward full or toward empty.
    for (int i = 0; i < 1100; i++) begin
      if (i % 100 == 0) fill = $urandom_range(1);
      calm = (i >= 500 && i < 600);
      case ($urandom_range(9))
        0, 1: op = fill ? CMD_INSERT : CMD_REMOVE;
        2: op = fill ? CMD_PUSH_FRONT : CMD_POP_FRONT;
        3: op = fill ? CMD_PUSH_BACK : CMD_POP_BACK;
        4: op = CMD_INSERT;
        5: op = CMD_REMOVE;
        6: op = 3'($urandom_range(2));
        7: op = 3'(3 + $urandom_range(1));
        8: op = ($urandom_range(19) == 0) ? 3'(6 + $urandom_range(1)) : CMD_INSERT;
        default: op = 3'($urandom_range(5));
      endcase
      send_cmd(op, pool_key(), pool_value());
      if (i == 800) drain_results();   // sender pause until everything is back
    end
    calm = 1'b0;
    drain_results();
    repeat (100) @(posedge clk);

    $display("Covered %0d transactions, %0d rejected, list depth up to %0d.",
             board.checked, board.fail_hits, max_depth);
    $display("Commands seen: pf %0d pb %0d ins %0d popf %0d popb %0d rm %0d bad %0d",
             board.op_hits[0], board.op_hits[1], board.op_hits[2], board.op_hits[3],
             board.op_hits[4], board.op_hits[5], board.op_hits[6] + board.op_hits[7]);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: ~1200 items plus walks and stalls, with wide margin.
  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
